FILE: sv/smwq_pkg.sv
package smwq_pkg;

    localparam int COUNT_W = 16;
    localparam int THREAD_W = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int ID_BITS_DEFAULT = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] INITIAL_COUNT_RESET = 16'd1;
    localparam logic MUTEX_MODE_RESET = 1'b1;

    localparam logic OP_WAIT = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUTEX_MODE = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_INCREMENTED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_WOKEN = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL_DROPPED = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_SATURATED = 3'd5;

    typedef struct packed {
        logic                op;
        logic [THREAD_W-1:0] tid;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [THREAD_W-1:0] woken_thread;
        logic                reacquire_error;
        logic                not_holder_error;
        logic [COUNT_W-1:0]  count_after;
    } res_t;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_t;

endpackage

FILE: sv/smwq_ram.sv
module smwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/smwq_core.sv
module smwq_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  smwq_pkg::cfg_t cfg,
    input  logic          item_valid,
    input  smwq_pkg::req_t req,
    output smwq_pkg::res_t res
);
    import smwq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int USED_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W = (ID_BITS < THREAD_W) ? ID_BITS : THREAD_W;

    logic               mutex_mode_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [ID_W-1:0]    holder_reg, holder_next;
    logic               holder_valid_reg, holder_valid_next;
    logic               byp_valid_reg;
    logic [ID_W-1:0]    byp_data_reg;

    logic [ID_W-1:0]  tid;
    logic [ID_W-1:0]  ram_rdata;
    logic [ID_W-1:0]  head_data;
    logic             push;
    logic             pop;
    logic             cfg_load;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    assign tid = req.tid[ID_W-1:0];
    assign cfg_load = cfg.we && (cfg.index == CFG_INITIAL_COUNT);
    assign head_data = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        holder_next = holder_reg;
        holder_valid_next = holder_valid_reg;
        push = 1'b0;
        pop = 1'b0;
        res.status = STATUS_GRANTED;
        res.woken_valid = 1'b0;
        res.woken_thread = '0;
        res.reacquire_error = 1'b0;
        res.not_holder_error = 1'b0;

        if (req.op == OP_WAIT)
        begin
            res.reacquire_error = mutex_mode_reg && holder_valid_reg && (holder_reg == tid);
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
                res.status = STATUS_GRANTED;
                if (mutex_mode_reg)
                begin
                    holder_next = tid;
                    holder_valid_next = 1'b1;
                end
            end
            else if (used_reg == USED_W'(QUEUE_DEPTH))
            begin
                res.status = STATUS_FULL_DROPPED;
            end
            else
            begin
                push = 1'b1;
                tail_next = tail_inc;
                used_next = used_reg + 1'b1;
                res.status = STATUS_QUEUED;
            end
        end
        else
        begin
            if (mutex_mode_reg)
            begin
                res.not_holder_error = !holder_valid_reg || (holder_reg != tid);
                holder_next = '0;
                holder_valid_next = 1'b0;
            end
            if (used_reg == '0)
            begin
                if (count_reg == COUNT_MAX)
                begin
                    res.status = STATUS_SATURATED;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    res.status = STATUS_INCREMENTED;
                end
            end
            else
            begin
                pop = 1'b1;
                head_next = head_inc;
                used_next = used_reg - 1'b1;
                res.status = STATUS_WOKEN;
                res.woken_valid = 1'b1;
                res.woken_thread = THREAD_W'(head_data);
                if (mutex_mode_reg)
                begin
                    holder_next = head_data;
                    holder_valid_next = 1'b1;
                end
            end
        end
        res.count_after = count_next;

        if (!item_valid)
        begin
            count_next = count_reg;
            head_next = head_reg;
            tail_next = tail_reg;
            used_next = used_reg;
            holder_next = holder_reg;
            holder_valid_next = holder_valid_reg;
            push = 1'b0;
            pop = 1'b0;
        end

        if (cfg_load)
        begin
            count_next = cfg.data[COUNT_W-1:0];
            head_next = '0;
            tail_next = '0;
            used_next = '0;
            holder_next = '0;
            holder_valid_next = 1'b0;
            push = 1'b0;
            pop = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mutex_mode_reg <= MUTEX_MODE_RESET;
            count_reg <= INITIAL_COUNT_RESET;
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
            holder_reg <= '0;
            holder_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.we && (cfg.index == CFG_MUTEX_MODE))
            begin
                mutex_mode_reg <= cfg.data[0];
            end
            count_reg <= count_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
            holder_reg <= holder_next;
            holder_valid_reg <= holder_valid_next;
            byp_valid_reg <= push && (tail_reg == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= tid;
    end

    smwq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_waiter_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (tid),
        .rd_addr (head_next),
        .rd_data (ram_rdata)
    );

    // The queue never holds more entries than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(QUEUE_DEPTH))
        else $error("waiter queue overfilled");

    // An empty queue has its read and write pointers together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with split pointers");

    // A grant takes exactly one unit from the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !cfg_load && (res.status == STATUS_GRANTED))
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("grant did not consume one unit");

    // A woken waiter leaves the queue one entry shorter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !cfg_load && res.woken_valid)
        |=> (used_reg == $past(used_reg) - 1'b1))
        else $error("wake did not pop the queue");

endmodule

FILE: sv/semaphore_mutex_wait_queue.sv
// Channel   Handshake              Fields
// command   start, busy            opcode, thread_id
// result    done (one-cycle)       status, woken_valid, woken_thread,
//                                  reacquire_error, not_holder_error, count_after
// config    cfg_we                 cfg_index, cfg_data
//
// A command is taken at every edge where start is high; busy stays low.
// Its result passes through the input register and the result register, which sit
// around the count, queue and holder update, and is then on the ports with done;
// the receiver takes it at the edge where done is high. One result per cycle.
// The waiter memory is read ahead at the next head.
// Reset loads the count with 1, empties the queue and clears the holder.
// The receiver cannot stall, so no result is ever held back.
module semaphore_mutex_wait_queue #(
    parameter int QUEUE_DEPTH = smwq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int ID_BITS = smwq_pkg::ID_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             opcode,
    input  logic [smwq_pkg::THREAD_W-1:0]    thread_id,
    output logic                             done,
    output logic [smwq_pkg::STATUS_W-1:0]    status,
    output logic                             woken_valid,
    output logic [smwq_pkg::THREAD_W-1:0]    woken_thread,
    output logic                             reacquire_error,
    output logic                             not_holder_error,
    output logic [smwq_pkg::COUNT_W-1:0]     count_after,
    input  logic                             cfg_we,
    input  logic [smwq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [smwq_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smwq_pkg::*;

    logic item_valid_reg;
    req_t item_req_reg;
    logic done_reg;
    res_t res_reg;
    res_t res;
    cfg_t cfg;

    assign busy = 1'b0;
    assign cfg.we = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
            done_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item_req_reg.op <= opcode;
        item_req_reg.tid <= thread_id;
        res_reg <= res;
    end

    smwq_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid_reg),
        .req        (item_req_reg),
        .res        (res)
    );

    assign done = done_reg;
    assign status = res_reg.status;
    assign woken_valid = res_reg.woken_valid;
    assign woken_thread = res_reg.woken_thread;
    assign reacquire_error = res_reg.reacquire_error;
    assign not_holder_error = res_reg.not_holder_error;
    assign count_after = res_reg.count_after;

endmodule
